// ===== hdl/lhdd_pkg.sv =====
// Shared types and constants for the luma histogram and dark-frame detector.
`default_nettype none
package lhdd_pkg;

	// Item selector carried in s_tuser
	typedef enum logic [1:0] {
		FUNC_ADD   = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_EVAL  = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	// One RGB pixel
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// Histogram geometry
	localparam int unsigned BIN_AW = 8;
	localparam int unsigned BINS   = 1 << BIN_AW;

	// Result field width and its saturation value
	localparam int unsigned OUT_W   = 24;
	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	// BT.601 weights in thousandths
	localparam int unsigned W_RED   = 299;
	localparam int unsigned W_GREEN = 587;
	localparam int unsigned W_BLUE  = 114;
	localparam int unsigned DIV     = 1000;

	// Weighted sum width (255 * 1000 < 2^18)
	localparam int unsigned ACC_W = 18;

	// Truncated reciprocal of 1000: 1048 / 2^20, estimate low by at most one
	localparam int unsigned RECIP       = 1048;
	localparam int unsigned RECIP_SHIFT = 20;
	localparam int unsigned RECIP_W     = 11;

endpackage
`default_nettype wire

// ===== hdl/luma_histogram_dark_detect_core.sv =====
// Luma histogram: add pixels, read bins, evaluate darkness, clear the store.
// Add item: 3-stage luma, read, write back, then the next item can be accepted.
// Read item: bin read, S_RDWAIT, S_OUT; evaluate: sum of bins 0 to dark_level-1.
// Clear item and reset: one sweep over all 256 bins of the memory, one bin a cycle.
// After arst_n is released the sweep runs first and s_tready stays low until it ends.
// Items are handled one at a time; the sequencer sets the pace and m_tready can hold it.
`default_nettype none
module luma_histogram_dark_detect_core #(
	parameter int unsigned COUNT_WIDTH = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config: dark_level
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // red[7:0], green[15:8], blue[23:16],
	                                   // bin_index[31:24], frame_pixels[55:32]
	input  wire logic [1:0]  s_tuser,  // func[1:0]
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0] m_tdata        // bin_count[23:0], is_dark[24],
	                                   // dark_total[48:25], zero pad[55:49]
);
	import lhdd_pkg::*;

	localparam int unsigned SW = ((COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W) + 1;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_LUMA   = 7'b0000010,
		S_INC    = 7'b0000100,
		S_RDWAIT = 7'b0001000,
		S_SUM    = 7'b0010000,
		S_OUT    = 7'b0100000,
		S_CLR    = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [7:0]             dark_level_q;
	logic [BIN_AW-1:0]      idx_q, addr_q;
	logic [OUT_W-1:0]       sum_q;
	logic [OUT_W-2:0]       half_q;
	logic [OUT_W-1:0]       res_count_q, res_total_q;
	logic                   res_dark_q;
	logic                   m_tvalid_q;
	logic [55:0]            m_tdata_q;

	logic                   accept;
	func_t                  func;
	pixel_t                 pixel;
	logic                   luma_done;
	logic [7:0]             luma;
	logic                   more;
	logic                   out_free;
	logic [SW-1:0]          sum_wide, cnt_wide;
	logic [OUT_W-1:0]       sum_sat, cnt_sat;
	logic [COUNT_WIDTH-1:0] inc_data;

	// bin memory and its port controls
	logic [COUNT_WIDTH-1:0] bins_mem [BINS];
	logic [COUNT_WIDTH-1:0] rd_data_q;
	logic                   mem_re, mem_we;
	logic [BIN_AW-1:0]      mem_raddr, mem_waddr;
	logic [COUNT_WIDTH-1:0] mem_wdata;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign func      = func_t'(s_tuser);
	assign pixel     = s_tdata[23:0];
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_free  = !m_tvalid_q || m_tready;

	lhdd_luma u_luma (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && func == FUNC_ADD),
		.pixel  (pixel),
		.done   (luma_done),
		.luma   (luma)
	);

	// saturating arithmetic on the read data
	assign sum_wide = SW'(sum_q) + SW'(rd_data_q);
	assign sum_sat  = (sum_wide > SW'(OUT_MAX)) ? OUT_MAX : sum_wide[OUT_W-1:0];
	assign cnt_wide = SW'(rd_data_q);
	assign cnt_sat  = (cnt_wide > SW'(OUT_MAX)) ? OUT_MAX : cnt_wide[OUT_W-1:0];
	assign inc_data = (rd_data_q == '1) ? rd_data_q : rd_data_q + COUNT_WIDTH'(1);
	assign more     = ({1'b0, idx_q} + 9'd1) < {1'b0, dark_level_q};

	// memory port selection
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = inc_data;
		unique case (state_q)
			S_IDLE: begin
				if (accept && func == FUNC_READ) begin
					mem_re    = 1'b1;
					mem_raddr = s_tdata[31:24];
				end else if (accept && func == FUNC_EVAL && dark_level_q != '0) begin
					mem_re = 1'b1;
				end
			end
			S_LUMA: begin
				mem_re    = luma_done;
				mem_raddr = luma;
			end
			S_SUM: begin
				mem_re    = more;
				mem_raddr = idx_q + BIN_AW'(1);
			end
			S_INC: begin
				mem_we = 1'b1;
			end
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = '0;
			end
			S_RDWAIT, S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bins_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= bins_mem[mem_raddr];
		end
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_level_q <= 8'd15;
		end else if (cfg_valid && cfg_ready) begin
			dark_level_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						case (func)
							FUNC_ADD:   state_q <= S_LUMA;
							FUNC_READ:  state_q <= S_RDWAIT;
							FUNC_EVAL:  state_q <= (dark_level_q != '0) ? S_SUM : S_OUT;
							FUNC_CLEAR: state_q <= S_CLR;
							default:    state_q <= S_IDLE;
						endcase
					end
				end
				S_LUMA: begin
					if (luma_done) begin
						state_q <= S_INC;
					end
				end
				S_INC:    state_q <= S_IDLE;
				S_RDWAIT: state_q <= S_OUT;
				S_SUM: begin
					if (more) begin
						idx_q <= idx_q + BIN_AW'(1);
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_CLR: begin
					idx_q <= idx_q + BIN_AW'(1);
					if (idx_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-item working registers and pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q       <= '0;
			half_q      <= s_tdata[55:33];
			res_count_q <= '0;
			res_total_q <= '0;
			res_dark_q  <= 1'b0;
		end
		if (state_q == S_LUMA && luma_done) begin
			addr_q <= luma;
		end
		if (state_q == S_RDWAIT) begin
			res_count_q <= cnt_sat;
		end
		if (state_q == S_SUM) begin
			sum_q <= sum_sat;
			if (!more) begin
				res_total_q <= sum_sat;
				res_dark_q  <= sum_sat > {1'b0, half_q};
			end
		end
		if (state_q == S_OUT && out_free) begin
			m_tdata_q <= {7'd0, res_total_q, res_dark_q, res_count_q};
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_inc_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INC) |-> (inc_data != '0))
		else $error("bin increment wrapped to zero");

	a_sum_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |-> (idx_q < dark_level_q))
		else $error("dark sum walked past dark level");

	a_luma_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		luma_done |-> (state_q == S_LUMA))
		else $error("luma result outside add item");

	a_dark_needs_total: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[24]) |-> (m_tdata[48:25] != '0))
		else $error("dark flag with zero dark total");
`endif

endmodule
`default_nettype wire

// ===== hdl/lhdd_luma.sv =====
// Three-stage pipeline that turns an RGB pixel into floor((299r+587g+114b)/1000).
`default_nettype none
module lhdd_luma (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire lhdd_pkg::pixel_t pixel,
	output logic                  done,
	output logic [7:0]            luma
);
	import lhdd_pkg::*;

	localparam int unsigned PROD_W = ACC_W + RECIP_W;

	logic              v_s1, v_s2, done_s3;
	logic [ACC_W-1:0]  acc_s1, acc_s2;
	logic [7:0]        q_s2, luma_s3;
	logic [PROD_W-1:0] prod;
	logic [ACC_W-1:0]  rem;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			v_s1    <= start;
			v_s2    <= v_s1;
			done_s3 <= v_s2;
		end
	end

	// reciprocal estimate and remainder check
	assign prod = PROD_W'(acc_s1) * PROD_W'(RECIP);
	assign rem  = acc_s2 - ACC_W'(q_s2) * ACC_W'(DIV);

	// stage 1: weighted sum, stage 2: quotient estimate, stage 3: fix-up
	always_ff @(posedge clk) begin
		if (start) begin
			acc_s1 <= ACC_W'(pixel.red) * ACC_W'(W_RED)
				+ ACC_W'(pixel.green) * ACC_W'(W_GREEN)
				+ ACC_W'(pixel.blue) * ACC_W'(W_BLUE);
		end
		acc_s2  <= acc_s1;
		q_s2    <= prod[RECIP_SHIFT +: 8];
		luma_s3 <= (rem >= ACC_W'(DIV)) ? q_s2 + 8'd1 : q_s2;
	end

	assign done = done_s3;
	assign luma = luma_s3;

endmodule
`default_nettype wire
